// ===== hw/rtl/afm_pkg.sv =====
`default_nettype none

package afm_pkg;

    // Fixed field widths of the request and result channels
    localparam int OUT_W  = 32;
    localparam int ALPH_W = 9;
    localparam int SYM_W  = 8;

    localparam logic [ALPH_W-1:0] ALPH_RESET = 9'd256;

    // Request type codes
    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // What the scan unit looks for while walking the counts
    typedef enum logic [1:0] {
        SCAN_ENCODE,   // the requested symbol itself
        SCAN_LOOKUP,   // the seen symbol whose interval covers the target
        SCAN_RANK      // the unseen symbol whose rank equals the target
    } scan_mode_t;

    typedef struct packed {
        logic       start;   // clear accumulators for a new request
        logic       step;    // a count word is present this cycle
        scan_mode_t mode;
    } scan_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/adaptive_escape_frequency_model.sv =====
// After a request is taken, the scan walks the stored counts of the active alphabet,
// one stored count per cycle through the single count memory read port, then a drain
// and a finish step register the first result; the second result of a new symbol
// follows once the first is taken. A new request is taken only in the idle state, after
// the last result of the previous one is registered. Reset: synchronous, active low;
// afterward a clearing pass zeroes the count memory while no request is taken.
`default_nettype none

module adaptive_escape_frequency_model
    import afm_pkg::*;
#(
    parameter int MAX_SYMBOLS = 256,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration write
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [ALPH_W-1:0] cfg_alphabet_size,
    // request channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_req_type,
    input  wire logic [SYM_W-1:0]  s_symbol,
    input  wire logic [OUT_W-1:0]  s_cum_value,
    // result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [OUT_W-1:0]       m_range_low,
    output logic [OUT_W-1:0]       m_range_high,
    output logic [OUT_W-1:0]       m_range_total,
    output logic [ALPH_W-1:0]      m_decoded_symbol,
    output logic                   m_is_escape,
    output logic                   m_last
);

    localparam int AW = $clog2(MAX_SYMBOLS);
    localparam int IW = $clog2(MAX_SYMBOLS + 1);
    localparam logic [COUNT_BITS-1:0] CNT_SAT = {{(COUNT_BITS-1){1'b1}}, 1'b0};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH,
        ST_EMIT2,
        ST_UPDATE
    } state_t;

    state_t                state_reg;
    logic [ALPH_W-1:0]     alph_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic                  pending_reg;
    logic [IW-1:0]         idx_reg;
    logic                  rd_valid_reg;
    logic [IW-1:0]         rd_idx_reg;
    logic                  req_reg;
    logic [SYM_W-1:0]      sym_reg;
    logic [OUT_W-1:0]      cum_reg;

    logic                  m_valid_reg;
    logic [OUT_W-1:0]      m_low_reg;
    logic [OUT_W-1:0]      m_high_reg;
    logic [OUT_W-1:0]      m_total_reg;
    logic [ALPH_W-1:0]     m_sym_reg;
    logic                  m_esc_reg;
    logic                  m_last_reg;

    logic [ALPH_W-1:0]     a_eff;
    logic [IW-1:0]         a_lim;
    logic [COUNT_BITS-1:0] total_p1;
    logic                  out_free;
    logic                  emit_now;
    logic                  accept;
    logic                  do_count;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [COUNT_BITS-1:0] mem_rdata;

    scan_ctrl_t            scan_ctrl;
    logic                  hit;
    logic [IW-1:0]         hit_idx;
    logic [COUNT_BITS-1:0] hit_low;
    logic [COUNT_BITS-1:0] hit_end;
    logic [COUNT_BITS-1:0] hit_cnt;
    logic [IW-1:0]         hit_rank;
    logic [IW-1:0]         unseen;

    // Active alphabet: zero acts as one, clamp to the memory depth
    always_comb begin
        if (alph_reg == '0) begin
            a_eff = 9'd1;
        end else if (32'(alph_reg) > MAX_SYMBOLS) begin
            a_eff = ALPH_W'(MAX_SYMBOLS);
        end else begin
            a_eff = alph_reg;
        end
    end

    assign a_lim    = IW'(a_eff);
    assign total_p1 = total_reg + COUNT_BITS'(1);
    assign out_free = !m_valid_reg || m_ready;
    assign emit_now = out_free && ((state_reg == ST_FINISH) || (state_reg == ST_EMIT2));
    assign accept   = s_valid && s_ready;
    assign do_count = (total_reg < CNT_SAT);

    // Memory write: clearing pass, or the count update of an encode
    assign mem_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_UPDATE) && do_count);
    assign mem_waddr = (state_reg == ST_CLEAR) ? idx_reg[AW-1:0] : AW'(sym_reg);
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : (hit_cnt + COUNT_BITS'(1));

    afm_count_ram #(
        .DEPTH (MAX_SYMBOLS),
        .WIDTH (COUNT_BITS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (mem_rdata)
    );

    // Scan unit control
    always_comb begin
        scan_ctrl.start = accept;
        scan_ctrl.step  = rd_valid_reg;
        if (req_reg == REQ_ENCODE) begin
            scan_ctrl.mode = SCAN_ENCODE;
        end else if (pending_reg) begin
            scan_ctrl.mode = SCAN_RANK;
        end else begin
            scan_ctrl.mode = SCAN_LOOKUP;
        end
    end

    afm_scan_unit #(
        .COUNT_BITS (COUNT_BITS),
        .IW         (IW)
    ) u_scan (
        .aclk     (aclk),
        .ctrl     (scan_ctrl),
        .idx      (rd_idx_reg),
        .data     (mem_rdata),
        .target   (IW'(sym_reg)),
        .cum      (cum_reg),
        .hit      (hit),
        .hit_idx  (hit_idx),
        .hit_low  (hit_low),
        .hit_end  (hit_end),
        .hit_cnt  (hit_cnt),
        .hit_rank (hit_rank),
        .zeros    (unseen)
    );

    // Sequencer, model state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            alph_reg     <= ALPH_RESET;
            total_reg    <= '0;
            pending_reg  <= 1'b0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // a count word comes out of the memory the cycle after each scan step
            rd_valid_reg <= (state_reg == ST_SCAN);

            if (cfg_valid && cfg_ready) begin
                alph_reg <= cfg_alphabet_size;
            end

            if (emit_now) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: begin
                    if (idx_reg == IW'(MAX_SYMBOLS - 1)) begin
                        idx_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end

                ST_IDLE: begin
                    if (accept) begin
                        req_reg <= s_req_type;
                        sym_reg <= s_symbol;
                        cum_reg <= s_cum_value;
                        idx_reg <= '0;
                        // encode of a symbol outside the alphabet gives nothing
                        if (s_req_type == REQ_LOOKUP || {1'b0, s_symbol} < a_eff) begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end

                ST_SCAN: begin
                    rd_idx_reg <= idx_reg;
                    if (idx_reg == a_lim - IW'(1)) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end

                // last count word is folded in this cycle
                ST_DRAIN: begin
                    state_reg <= ST_FINISH;
                end

                ST_FINISH: begin
                    if (out_free) begin
                        if (req_reg == REQ_ENCODE) begin
                            if (hit_cnt != '0) begin
                                m_low_reg   <= OUT_W'(hit_low);
                                m_high_reg  <= OUT_W'(hit_end);
                                m_total_reg <= OUT_W'(total_p1);
                                m_sym_reg   <= {1'b0, sym_reg};
                                m_esc_reg   <= 1'b0;
                                m_last_reg  <= 1'b1;
                                state_reg   <= ST_UPDATE;
                            end else begin
                                // new symbol: escape first, rank follows
                                m_low_reg   <= OUT_W'(total_reg);
                                m_high_reg  <= OUT_W'(total_p1);
                                m_total_reg <= OUT_W'(total_p1);
                                m_sym_reg   <= a_eff;
                                m_esc_reg   <= 1'b1;
                                m_last_reg  <= 1'b0;
                                state_reg   <= ST_EMIT2;
                            end
                        end else if (pending_reg) begin
                            // rank lookup after an escape
                            pending_reg <= 1'b0;
                            m_total_reg <= OUT_W'(total_p1);
                            m_esc_reg   <= 1'b0;
                            m_last_reg  <= 1'b1;
                            if (hit) begin
                                m_low_reg  <= cum_reg;
                                m_high_reg <= cum_reg + OUT_W'(1);
                                m_sym_reg  <= ALPH_W'(hit_idx);
                            end else begin
                                m_low_reg  <= '0;
                                m_high_reg <= '0;
                                m_sym_reg  <= a_eff;
                            end
                            state_reg <= ST_IDLE;
                        end else begin
                            m_last_reg <= 1'b1;
                            if (hit) begin
                                m_low_reg   <= OUT_W'(hit_low);
                                m_high_reg  <= OUT_W'(hit_end);
                                m_total_reg <= OUT_W'(total_p1);
                                m_sym_reg   <= ALPH_W'(hit_idx);
                                m_esc_reg   <= 1'b0;
                            end else begin
                                // no seen symbol covers the value: escape
                                pending_reg <= 1'b1;
                                m_low_reg   <= OUT_W'(total_reg);
                                m_high_reg  <= OUT_W'(total_p1);
                                m_total_reg <= OUT_W'(unseen);
                                m_sym_reg   <= a_eff;
                                m_esc_reg   <= 1'b1;
                            end
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                ST_EMIT2: begin
                    if (out_free) begin
                        m_low_reg   <= OUT_W'(hit_rank);
                        m_high_reg  <= OUT_W'(hit_rank) + OUT_W'(1);
                        m_total_reg <= OUT_W'(unseen);
                        m_sym_reg   <= {1'b0, sym_reg};
                        m_esc_reg   <= 1'b0;
                        m_last_reg  <= 1'b1;
                        state_reg   <= ST_UPDATE;
                    end
                end

                // count the encoded symbol unless the total is saturated
                ST_UPDATE: begin
                    if (do_count) begin
                        total_reg <= total_p1;
                    end
                    state_reg <= ST_IDLE;
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready        = 1'b1;
    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_range_low      = m_low_reg;
    assign m_range_high     = m_high_reg;
    assign m_range_total    = m_total_reg;
    assign m_decoded_symbol = m_sym_reg;
    assign m_is_escape      = m_esc_reg;
    assign m_last           = m_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/afm_count_ram.sv =====
`default_nettype none

module afm_count_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/afm_scan_unit.sv =====
`default_nettype none

module afm_scan_unit
    import afm_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int IW         = 9
) (
    input  wire logic                  aclk,
    input  wire scan_ctrl_t            ctrl,
    input  wire logic [IW-1:0]         idx,
    input  wire logic [COUNT_BITS-1:0] data,
    input  wire logic [IW-1:0]         target,
    input  wire logic [OUT_W-1:0]      cum,
    output logic                       hit,
    output logic [IW-1:0]              hit_idx,
    output logic [COUNT_BITS-1:0]      hit_low,
    output logic [COUNT_BITS-1:0]      hit_end,
    output logic [COUNT_BITS-1:0]      hit_cnt,
    output logic [IW-1:0]              hit_rank,
    output logic [IW-1:0]              zeros
);

    localparam int CW = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

    logic [COUNT_BITS-1:0] sum_reg;
    logic [IW-1:0]         zeros_reg;
    logic                  hit_reg;
    logic [COUNT_BITS-1:0] sum_plus;
    logic [CW-1:0]         cum_ext;
    logic [CW-1:0]         lo_ext;
    logic [CW-1:0]         hi_ext;
    logic                  match;

    // Shared adder and compare
    assign sum_plus = sum_reg + data;
    assign cum_ext  = CW'(cum);
    assign lo_ext   = CW'(sum_reg);
    assign hi_ext   = CW'(sum_plus);

    always_comb begin
        case (ctrl.mode)
            SCAN_ENCODE: match = (idx == target);
            SCAN_LOOKUP: match = (data != '0) && (cum_ext >= lo_ext) && (cum_ext < hi_ext);
            SCAN_RANK:   match = (data == '0) && (CW'(zeros_reg) == cum_ext);
            default:     match = 1'b0;
        endcase
    end

    // Running sum, zero count and first-match capture
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            sum_reg   <= '0;
            zeros_reg <= '0;
            hit_reg   <= 1'b0;
        end else if (ctrl.step) begin
            sum_reg <= sum_plus;
            if (data == '0) begin
                zeros_reg <= zeros_reg + IW'(1);
            end
            if (match && !hit_reg) begin
                hit_reg  <= 1'b1;
                hit_idx  <= idx;
                hit_low  <= sum_reg;
                hit_end  <= sum_plus;
                hit_cnt  <= data;
                hit_rank <= zeros_reg;
            end
        end
    end

    assign hit   = hit_reg;
    assign zeros = zeros_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/afm_checker.sv =====
`default_nettype none

module afm_checker
    import afm_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_ready,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic [OUT_W-1:0] m_range_low,
    input wire logic [OUT_W-1:0] m_range_high,
    input wire logic             m_is_escape,
    input wire logic             m_last
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_range_low) && $stable(m_range_high))
        else $error("result changed while stalled");

    // Escape interval is always one wide
    a_esc_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_escape |-> m_range_high == m_range_low + 32'd1)
        else $error("escape interval not one wide");

    // Only the escape of a new symbol is followed by a second result
    a_nonlast_esc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_is_escape)
        else $error("non-final result is not an escape");

    // No new request while the second result is still owed
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> !s_ready)
        else $error("request taken before rank result");

endmodule

bind adaptive_escape_frequency_model afm_checker u_afm_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_range_low  (m_range_low),
    .m_range_high (m_range_high),
    .m_is_escape  (m_is_escape),
    .m_last       (m_last)
);

`default_nettype wire
